// ----- rtl/voxel_face_culling_macros.svh -----
// Assertion macros for the voxel face culling block.
// Used by voxel_face_culling.sv; the bodies expect clk and rst in scope.
`ifndef VOXEL_FACE_CULLING_MACROS_SVH
`define VOXEL_FACE_CULLING_MACROS_SVH
`ifndef SYNTH
`define VFC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("voxel_face_culling: implication check failed");
`define VFC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("voxel_face_culling: next-cycle check failed");
`else
`define VFC_ASSERT_IMP(label, ante, cons)
`define VFC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- rtl/vfc_pkg.sv -----
// Shared types, constants and helpers for the voxel face culling block.
// No dependencies; used by voxel_face_culling.sv.
`default_nettype none
package vfc_pkg;

  localparam int CHUNK_SIDE_DEF = 16;
  localparam int MAX_LAYERS_DEF = 16;

  localparam int POS_W    = 4;
  localparam int CODE_W   = 4;
  localparam int MASK_W   = 6;
  localparam int COUNT_W  = 3;
  localparam int VTX_W    = 17;
  localparam int HEIGHT_W = 5;
  localparam int CFG_W    = 5;
  localparam int REGIDX_W = 1;
  localparam int STEP_W   = 3;

  localparam logic [REGIDX_W-1:0] REG_HEIGHT = 1'd0;
  localparam logic [REGIDX_W-1:0] REG_AIR    = 1'd1;

  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 5'd16;
  localparam logic [CODE_W-1:0]   AIR_RESET    = 4'd0;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_MESH  = 1'b1;

  // Read order of one mesh item: the cell itself, then its six neighbors.
  localparam logic [STEP_W-1:0] STEP_CELL   = 3'd0;
  localparam logic [STEP_W-1:0] STEP_LEFT   = 3'd1;
  localparam logic [STEP_W-1:0] STEP_BACK   = 3'd2;
  localparam logic [STEP_W-1:0] STEP_RIGHT  = 3'd3;
  localparam logic [STEP_W-1:0] STEP_FRONT  = 3'd4;
  localparam logic [STEP_W-1:0] STEP_TOP    = 3'd5;
  localparam logic [STEP_W-1:0] STEP_BOTTOM = 3'd6;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_FETCH = 4'b0010,
    S_DRAIN = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  function automatic logic [COUNT_W-1:0] face_popcount(input logic [MASK_W-1:0] m);
    logic [COUNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < MASK_W; i++) begin
      n = n + COUNT_W'(m[i]);
    end
    return n;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/voxel_face_culling.sv -----
// Top level of the voxel face culling block: voxel memory, read sequencer
// and vertex counter. Depends on vfc_pkg and voxel_face_culling_macros.svh.
//
// Usage: an item is taken at a rising edge with start high and busy low.
// A write item (req_type 0) stores block_code at pos_x/pos_z/pos_y in that
// same edge and is finished at once; busy stays low, so one write is taken
// every cycle while no mesh item is in flight. A mesh item (req_type 1)
// raises busy through S_FETCH, S_DRAIN and S_EMIT: S_FETCH does one read
// of the single-port voxel memory per cycle, the cell and then its six
// neighbors, S_DRAIN takes the last read data, and S_EMIT forms the mask,
// face count and base vertex. done is registered from S_EMIT, and the next
// item may be taken in that same cycle. A new mesh item is taken only once
// the last one has left S_EMIT. Configuration writes (cfg_we, cfg_index,
// cfg_data) take effect at the next edge; they are to be made only while no
// mesh item is in flight, which the block itself does not enforce. Reset
// (rst, synchronous) returns to idle, clears the vertex counter and loads
// height 16 and air code 0; the voxel memory is not cleared and must be
// written before it is read. The receiver cannot stall: done is a one-cycle
// strobe that must be taken when shown.
`default_nettype none
`include "voxel_face_culling_macros.svh"
module voxel_face_culling #(
  parameter int CHUNK_SIDE = vfc_pkg::CHUNK_SIDE_DEF,
  parameter int MAX_LAYERS = vfc_pkg::MAX_LAYERS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [vfc_pkg::REGIDX_W-1:0] cfg_index,
  input  wire logic [vfc_pkg::CFG_W-1:0]    cfg_data,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic                         req_type,
  input  wire logic [vfc_pkg::POS_W-1:0]    pos_x,
  input  wire logic [vfc_pkg::POS_W-1:0]    pos_z,
  input  wire logic [vfc_pkg::POS_W-1:0]    pos_y,
  input  wire logic [vfc_pkg::CODE_W-1:0]   block_code,
  input  wire logic                         first_cell,
  output logic                              done,
  output logic [vfc_pkg::POS_W-1:0]         out_x,
  output logic [vfc_pkg::POS_W-1:0]         out_z,
  output logic [vfc_pkg::POS_W-1:0]         out_y,
  output logic [vfc_pkg::CODE_W-1:0]        cell_code,
  output logic [vfc_pkg::MASK_W-1:0]        face_mask,
  output logic [vfc_pkg::COUNT_W-1:0]       face_count,
  output logic [vfc_pkg::VTX_W-1:0]         base_vertex
);

  localparam int DEPTH  = CHUNK_SIDE * CHUNK_SIDE * MAX_LAYERS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CMP_W  = $clog2(CHUNK_SIDE + MAX_LAYERS + (1 << vfc_pkg::POS_W)) + 1;
  localparam int VTX_PAD = vfc_pkg::VTX_W - vfc_pkg::COUNT_W - 2;
  localparam logic [ADDR_W-1:0] ROW_STRIDE   = ADDR_W'(CHUNK_SIDE);
  localparam logic [ADDR_W-1:0] LAYER_STRIDE = ADDR_W'(CHUNK_SIDE * CHUNK_SIDE);

  // Configuration registers.
  logic [vfc_pkg::HEIGHT_W-1:0] height_in_use;
  logic [vfc_pkg::CODE_W-1:0]   air_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      height_in_use <= vfc_pkg::HEIGHT_RESET;
      air_code      <= vfc_pkg::AIR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        vfc_pkg::REG_HEIGHT: height_in_use <= cfg_data[vfc_pkg::HEIGHT_W-1:0];
        vfc_pkg::REG_AIR:    air_code      <= cfg_data[vfc_pkg::CODE_W-1:0];
        default: ;
      endcase
    end
  end

  vfc_pkg::state_t state, state_next;

  logic [vfc_pkg::POS_W-1:0]  cur_x, cur_z, cur_y;
  logic [ADDR_W-1:0]          cen_addr;
  logic                       cur_inside;
  logic [vfc_pkg::STEP_W-1:0] step;
  logic [vfc_pkg::STEP_W-1:0] rd_step;
  logic                       rd_vld;
  logic [vfc_pkg::CODE_W-1:0] rd_data;
  logic [vfc_pkg::CODE_W-1:0] cell_q;
  logic                       cell_air;
  logic [vfc_pkg::MASK_W-1:0] acc_mask;
  logic [vfc_pkg::VTX_W-1:0]  vertex_counter;

  logic [vfc_pkg::CODE_W-1:0] mem [DEPTH];

  logic                       accept, accept_mesh, in_inside;
  logic [ADDR_W-1:0]          in_addr;
  logic [CMP_W-1:0]           height_sat;
  logic [vfc_pkg::MASK_W-1:0] edge_mask;
  logic [ADDR_W-1:0]          nb_offset, nb_addr, rd_addr;
  logic                       nb_sub, nb_edge, rd_en, is_air;
  logic [vfc_pkg::STEP_W-1:0] nb_idx;
  logic                       active;
  logic [vfc_pkg::MASK_W-1:0] final_mask;
  logic [vfc_pkg::COUNT_W-1:0] final_count;

  assign busy        = (state != vfc_pkg::S_IDLE);
  assign accept      = start && !busy;
  assign accept_mesh = accept && (req_type == vfc_pkg::REQ_MESH);

  assign in_inside = (CMP_W'(pos_x) < CMP_W'(CHUNK_SIDE)) &&
                     (CMP_W'(pos_z) < CMP_W'(CHUNK_SIDE)) &&
                     (CMP_W'(pos_y) < CMP_W'(MAX_LAYERS));
  assign in_addr = ADDR_W'(pos_x) + ADDR_W'(pos_z) * ROW_STRIDE +
                   ADDR_W'(pos_y) * LAYER_STRIDE;

  assign height_sat = (CMP_W'(height_in_use) > CMP_W'(MAX_LAYERS)) ?
                      CMP_W'(MAX_LAYERS) : CMP_W'(height_in_use);

  // Faces on the chunk boundary are visible without a neighbor read.
  assign edge_mask[0] = (cur_x == '0);
  assign edge_mask[1] = (cur_z == '0);
  assign edge_mask[2] = (CMP_W'(cur_x) == CMP_W'(CHUNK_SIDE - 1));
  assign edge_mask[3] = (CMP_W'(cur_z) == CMP_W'(CHUNK_SIDE - 1));
  assign edge_mask[4] = ((CMP_W'(cur_y) + CMP_W'(1)) >= height_sat);
  assign edge_mask[5] = (cur_y == '0);

  // One shared add/subtract unit forms each neighbor address.
  always_comb begin
    nb_offset = ADDR_W'(1);
    nb_sub    = 1'b0;
    nb_edge   = 1'b1;
    case (step)
      vfc_pkg::STEP_LEFT: begin
        nb_offset = ADDR_W'(1);
        nb_sub    = 1'b1;
        nb_edge   = edge_mask[0];
      end
      vfc_pkg::STEP_BACK: begin
        nb_offset = ROW_STRIDE;
        nb_sub    = 1'b1;
        nb_edge   = edge_mask[1];
      end
      vfc_pkg::STEP_RIGHT: begin
        nb_offset = ADDR_W'(1);
        nb_edge   = edge_mask[2];
      end
      vfc_pkg::STEP_FRONT: begin
        nb_offset = ROW_STRIDE;
        nb_edge   = edge_mask[3];
      end
      vfc_pkg::STEP_TOP: begin
        nb_offset = LAYER_STRIDE;
        nb_edge   = edge_mask[4];
      end
      vfc_pkg::STEP_BOTTOM: begin
        nb_offset = LAYER_STRIDE;
        nb_sub    = 1'b1;
        nb_edge   = edge_mask[5];
      end
      default: ;
    endcase
  end

  assign nb_addr = nb_sub ? (cen_addr - nb_offset) : (cen_addr + nb_offset);
  assign rd_addr = nb_edge ? cen_addr : nb_addr;
  assign rd_en   = (state == vfc_pkg::S_FETCH) && cur_inside;

  // Single-port voxel memory: writes only when idle, reads only while fetching.
  always_ff @(posedge clk) begin
    if (accept && (req_type == vfc_pkg::REQ_WRITE) && in_inside) begin
      mem[in_addr] <= block_code;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  assign is_air = (rd_data == air_code);
  assign nb_idx = rd_step - vfc_pkg::STEP_W'(1);

  always_comb begin
    state_next = state;
    unique case (state)
      vfc_pkg::S_IDLE:  if (accept_mesh) state_next = vfc_pkg::S_FETCH;
      vfc_pkg::S_FETCH: if (step == vfc_pkg::STEP_BOTTOM) state_next = vfc_pkg::S_DRAIN;
      vfc_pkg::S_DRAIN: state_next = vfc_pkg::S_EMIT;
      vfc_pkg::S_EMIT:  state_next = vfc_pkg::S_IDLE;
      default:          state_next = vfc_pkg::S_IDLE;
    endcase
  end

  assign active = cur_inside && !cell_air && (CMP_W'(cur_y) < height_sat);
  assign final_mask  = active ? acc_mask : '0;
  assign final_count = vfc_pkg::face_popcount(final_mask);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= vfc_pkg::S_IDLE;
      step           <= vfc_pkg::STEP_CELL;
      rd_vld         <= 1'b0;
      done           <= 1'b0;
      vertex_counter <= '0;
    end else begin
      state  <= state_next;
      done   <= (state == vfc_pkg::S_EMIT);
      rd_vld <= rd_en;
      if (state == vfc_pkg::S_FETCH) begin
        step <= step + vfc_pkg::STEP_W'(1);
      end else begin
        step <= vfc_pkg::STEP_CELL;
      end
      if (accept_mesh && first_cell) begin
        vertex_counter <= '0;
      end else if (state == vfc_pkg::S_EMIT) begin
        vertex_counter <= vertex_counter + {VTX_PAD'(0), final_count, 2'b00};
      end
    end
  end

  // Item registers and result collection.
  always_ff @(posedge clk) begin
    if (accept_mesh) begin
      cur_x      <= pos_x;
      cur_z      <= pos_z;
      cur_y      <= pos_y;
      cen_addr   <= in_addr;
      cur_inside <= in_inside;
      cell_q     <= '0;
      cell_air   <= 1'b0;
      acc_mask   <= '0;
    end
    if (state == vfc_pkg::S_FETCH) begin
      rd_step <= step;
    end
    if (rd_vld) begin
      if (rd_step == vfc_pkg::STEP_CELL) begin
        cell_q   <= rd_data;
        cell_air <= is_air;
      end else begin
        acc_mask[nb_idx] <= edge_mask[nb_idx] || is_air;
      end
    end
    if (state == vfc_pkg::S_EMIT) begin
      out_x       <= cur_x;
      out_z       <= cur_z;
      out_y       <= cur_y;
      cell_code   <= cur_inside ? cell_q : '0;
      face_mask   <= final_mask;
      face_count  <= final_count;
      base_vertex <= vertex_counter;
    end
  end

  `VFC_ASSERT_IMP(a_done_after_emit, done, $past(state == vfc_pkg::S_EMIT))
  `VFC_ASSERT_IMP(a_count_matches, done, face_count == $countones(face_mask))
  `VFC_ASSERT_IMP(a_air_no_faces, done && (face_mask != '0), cell_code != air_code)
  `VFC_ASSERT_NEXT(a_mesh_goes_busy, accept_mesh, busy && !done)

endmodule
`default_nettype wire
